@@ rtl/core/tpsm_pkg.sv @@
// ============================================================================
// tpsm_pkg
// Shared constants, types and the channel average function of the three-tap
// pixel smoother.
// ============================================================================
package tpsm_pkg;

    // Line store depth and counter widths.
    localparam int MAX_WIDTH    = 4096;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int EFF_W_W      = COL_W + 1;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
    localparam int EFF_H_W      = ROW_W + 1;

    // Configuration port.
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0]  CFG_FRAME_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0]  CFG_FRAME_HEIGHT = 8'd1;
    localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    // Queue between front and back.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_LVL_W = $clog2(Q_DEPTH + 1);

    // Divide by three: floor(s / 3) == (s * 683) >> 11 for every s up to 765.
    localparam logic [19:0] RECIP3       = 20'd683;
    localparam int          RECIP3_SHIFT = 11;

    typedef logic [31:0] t_pixel;

    // One classified pixel on its way from the front to the back.
    typedef struct packed {
        t_pixel above;      // stored pixel of the row above, same column
        t_pixel right;      // stored pixel of the row above, next column
        t_pixel px;         // incoming pixel
        logic   has_above;  // row above exists: one smoothed output
        logic   last_col;   // smoothed output passes the pixel above through
        logic   last_row;   // incoming pixel is also output unchanged
    } t_entry;

    // Per channel floor((a + b + c) / 3) over the four 8-bit channels.
    function automatic t_pixel avg3_pixel(input t_pixel a, input t_pixel b,
                                          input t_pixel c);
        logic [9:0]  s;
        logic [19:0] p;
        t_pixel      r;
        r = '0;
        for (int k = 0; k < 4; k++) begin
            s = 10'(a[8*k +: 8]) + 10'(b[8*k +: 8]) + 10'(c[8*k +: 8]);
            p = 20'(s) * RECIP3;
            r[8*k +: 8] = p[RECIP3_SHIFT +: 8];
        end
        return r;
    endfunction

endpackage

@@ rtl/core/tpsm_front.sv @@
// ============================================================================
// tpsm_front
// Accepts pixels, keeps the frame counters and the line store, reads the two
// neighbours from the row above and classifies each pixel for the back end.
// ============================================================================
module tpsm_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tpsm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tpsm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  tpsm_pkg::t_pixel                   i_in_pixel,
    input  logic [tpsm_pkg::Q_LVL_W-1:0]       i_q_level,
    output logic                               o_push_valid,
    output tpsm_pkg::t_entry                   o_push_entry
);

    logic [tpsm_pkg::CFG_DATA_W-1:0] r_frame_width;
    logic [tpsm_pkg::CFG_DATA_W-1:0] r_frame_height;
    logic [tpsm_pkg::COL_W-1:0]      r_col;
    logic [tpsm_pkg::ROW_W-1:0]      r_row;
    logic [tpsm_pkg::EFF_W_W-1:0]    w_eff_width;
    logic [tpsm_pkg::EFF_H_W-1:0]    w_eff_height;
    logic                            w_last_col;
    logic                            w_last_row;
    logic                            w_accept;
    logic [tpsm_pkg::COL_W-1:0]      w_right_addr;

    tpsm_pkg::t_pixel r_line [tpsm_pkg::MAX_WIDTH];
    tpsm_pkg::t_pixel r_above;
    tpsm_pkg::t_pixel r_right;
    tpsm_pkg::t_pixel r_s1_px;
    logic             r_s1_valid;
    logic             r_s1_has_above;
    logic             r_s1_last_col;
    logic             r_s1_last_row;

    assign o_cfg_ready = 1'b1;

    // Take a new beat only if the queue has room for it and for the one in flight.
    assign o_in_ready = (32'(i_q_level) + 32'(r_s1_valid)) < tpsm_pkg::Q_DEPTH;
    assign w_accept   = i_in_valid && o_in_ready;

    // Frame size clamped to the supported range.
    always_comb begin
        w_eff_width = tpsm_pkg::EFF_W_W'(r_frame_width);
        if (r_frame_width == '0) begin
            w_eff_width = tpsm_pkg::EFF_W_W'(1);
        end else if (32'(r_frame_width) > tpsm_pkg::MAX_WIDTH) begin
            w_eff_width = tpsm_pkg::EFF_W_W'(tpsm_pkg::MAX_WIDTH);
        end
        w_eff_height = tpsm_pkg::EFF_H_W'(r_frame_height);
        if (r_frame_height == '0) begin
            w_eff_height = tpsm_pkg::EFF_H_W'(1);
        end else if (32'(r_frame_height) > tpsm_pkg::HEIGHT_LIMIT) begin
            w_eff_height = tpsm_pkg::EFF_H_W'(tpsm_pkg::HEIGHT_LIMIT);
        end
    end

    // Position flags of the current pixel.
    assign w_last_col   = (tpsm_pkg::EFF_W_W'(r_col) + tpsm_pkg::EFF_W_W'(1)) == w_eff_width;
    assign w_last_row   = (tpsm_pkg::EFF_H_W'(r_row) + tpsm_pkg::EFF_H_W'(1)) == w_eff_height;
    assign w_right_addr = r_col + tpsm_pkg::COL_W'(1);

    // Configuration registers and frame counters; any register write restarts the frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= tpsm_pkg::FRAME_WIDTH_RST;
            r_frame_height <= tpsm_pkg::FRAME_HEIGHT_RST;
            r_col          <= '0;
            r_row          <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tpsm_pkg::CFG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg_data;
                    r_col         <= '0;
                    r_row         <= '0;
                end
                tpsm_pkg::CFG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_data;
                    r_col          <= '0;
                    r_row          <= '0;
                end
                default: begin
                end
            endcase
        end else if (w_accept) begin
            if (w_last_col) begin
                r_col <= '0;
                r_row <= w_last_row ? '0 : r_row + tpsm_pkg::ROW_W'(1);
            end else begin
                r_col <= r_col + tpsm_pkg::COL_W'(1);
            end
        end
    end

    // Line store: read the row above before the new pixel replaces it.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_above      <= r_line[r_col];
            r_right      <= r_line[w_right_addr];
            r_line[r_col] <= i_in_pixel;
        end
    end

    // Stage register that lines the pixel up with the read data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
        end
        if (w_accept) begin
            r_s1_px        <= i_in_pixel;
            r_s1_has_above <= r_row != '0;
            r_s1_last_col  <= w_last_col;
            r_s1_last_row  <= w_last_row;
        end
    end

    assign o_push_valid              = r_s1_valid;
    assign o_push_entry.above        = r_above;
    assign o_push_entry.right        = r_right;
    assign o_push_entry.px           = r_s1_px;
    assign o_push_entry.has_above    = r_s1_has_above;
    assign o_push_entry.last_col     = r_s1_last_col;
    assign o_push_entry.last_row     = r_s1_last_row;

endmodule

@@ rtl/core/tpsm_queue.sv @@
// ============================================================================
// tpsm_queue
// Short first-in first-out queue of classified pixels between the front and
// the back end.
// ============================================================================
module tpsm_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  tpsm_pkg::t_entry              i_push_entry,
    input  logic                          i_pop,
    output logic                          o_head_valid,
    output tpsm_pkg::t_entry              o_head_entry,
    output logic [tpsm_pkg::Q_LVL_W-1:0]  o_level
);

    tpsm_pkg::t_entry              r_slot [tpsm_pkg::Q_DEPTH];
    logic [tpsm_pkg::Q_PTR_W-1:0]  r_wr_ptr;
    logic [tpsm_pkg::Q_PTR_W-1:0]  r_rd_ptr;
    logic [tpsm_pkg::Q_LVL_W-1:0]  r_level;
    logic                          w_pop;

    assign o_head_valid = r_level != '0;
    assign o_head_entry = r_slot[r_rd_ptr];
    assign o_level      = r_level;
    assign w_pop        = i_pop && o_head_valid;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + tpsm_pkg::Q_PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + tpsm_pkg::Q_PTR_W'(1);
            end
            case ({i_push, w_pop})
                2'b10:   r_level <= r_level + tpsm_pkg::Q_LVL_W'(1);
                2'b01:   r_level <= r_level - tpsm_pkg::Q_LVL_W'(1);
                default: r_level <= r_level;
            endcase
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_entry;
        end
    end

endmodule

@@ rtl/core/tpsm_back.sv @@
// ============================================================================
// tpsm_back
// Turns each classified pixel into zero, one or two output beats and holds
// them in the output register until they are taken.
// ============================================================================
module tpsm_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_head_valid,
    input  tpsm_pkg::t_entry  i_head_entry,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output tpsm_pkg::t_pixel  o_out_pixel,
    output logic              o_out_last,
    output logic              o_out_eof
);

    typedef enum logic {
        PH_FIRST,
        PH_SECOND
    } t_phase;

    t_phase           r_phase;
    t_phase           n_phase;
    logic             r_out_valid;
    logic             n_out_valid;
    tpsm_pkg::t_pixel r_out_pixel;
    tpsm_pkg::t_pixel n_out_pixel;
    logic             r_out_last;
    logic             n_out_last;
    logic             r_out_eof;
    logic             n_out_eof;
    logic             w_load;
    tpsm_pkg::t_pixel w_smooth;

    assign w_smooth = tpsm_pkg::avg3_pixel(i_head_entry.above, i_head_entry.right,
                                           i_head_entry.px);
    assign w_load   = !r_out_valid || i_out_ready;

    // Pick the next output beat: the smoothed pixel above first, then the pass-through.
    always_comb begin
        o_pop       = 1'b0;
        n_phase     = r_phase;
        n_out_valid = r_out_valid;
        n_out_pixel = r_out_pixel;
        n_out_last  = r_out_last;
        n_out_eof   = r_out_eof;
        if (w_load) begin
            n_out_valid = 1'b0;
            if (i_head_valid) begin
                if (i_head_entry.has_above && (r_phase == PH_FIRST)) begin
                    n_out_valid = 1'b1;
                    n_out_pixel = i_head_entry.last_col ? i_head_entry.above : w_smooth;
                    n_out_eof   = 1'b0;
                    n_out_last  = !i_head_entry.last_row;
                    if (i_head_entry.last_row) begin
                        n_phase = PH_SECOND;
                    end else begin
                        o_pop = 1'b1;
                    end
                end else if (i_head_entry.last_row) begin
                    n_out_valid = 1'b1;
                    n_out_pixel = i_head_entry.px;
                    n_out_eof   = i_head_entry.last_col;
                    n_out_last  = 1'b1;
                    n_phase     = PH_FIRST;
                    o_pop       = 1'b1;
                end else begin
                    // First row of a taller frame: nothing to send yet.
                    o_pop = 1'b1;
                end
            end
        end
    end

    // Phase and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_FIRST;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
        r_out_pixel <= n_out_pixel;
        r_out_last  <= n_out_last;
        r_out_eof   <= n_out_eof;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_pixel = r_out_pixel;
    assign o_out_last  = r_out_last;
    assign o_out_eof   = r_out_eof;

endmodule

@@ rtl/core/three_tap_pixel_smoother_core.sv @@
// Throughput: one pixel per cycle while the output is taken; a last-row pixel gives
//   two beats, so there the single output register holds it for both and the input slows.
// Path: a beat leaves through the line store read register, the queue and the
//   output register after its pixel is accepted; outputs lag one line.
// Reset: counters clear, frame size returns to 640 x 480; the line store is
//   not cleared, since no entry is used before the current frame writes it.
// ============================================================================
// three_tap_pixel_smoother_core
// Three-tap ARGB smoother over each pixel, its right and its lower neighbour.
// ============================================================================
module three_tap_pixel_smoother_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [tpsm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tpsm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [31:0]                      s_axis_tdata,  // red, green, blue, alpha
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [31:0]                      m_axis_tdata,  // out_red, out_green, out_blue, out_alpha
    output logic                             m_axis_tlast,  // last_of_run
    output logic                             m_axis_tuser   // end_of_frame
);

    logic                          w_push_valid;
    tpsm_pkg::t_entry              w_push_entry;
    logic                          w_head_valid;
    tpsm_pkg::t_entry              w_head_entry;
    logic                          w_pop;
    logic [tpsm_pkg::Q_LVL_W-1:0]  w_q_level;

    tpsm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_in_pixel   (s_axis_tdata),
        .i_q_level    (w_q_level),
        .o_push_valid (w_push_valid),
        .o_push_entry (w_push_entry)
    );

    tpsm_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push_valid),
        .i_push_entry (w_push_entry),
        .i_pop        (w_pop),
        .o_head_valid (w_head_valid),
        .o_head_entry (w_head_entry),
        .o_level      (w_q_level)
    );

    tpsm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head_entry (w_head_entry),
        .o_pop        (w_pop),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_pixel  (m_axis_tdata),
        .o_out_last   (m_axis_tlast),
        .o_out_eof    (m_axis_tuser)
    );

`ifndef SYNTH
    // The front never pushes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push_valid |-> (32'(w_q_level) < tpsm_pkg::Q_DEPTH))
        else $error("queue push while full");

    // The back never pops an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head_valid)
        else $error("queue pop while empty");

    // End of frame only ever marks the last beat of a run.
    a_eof_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
        else $error("end of frame on a beat that is not last of its run");
`endif

endmodule
